FILE: hw/rtl/date_difference_in_days_macros.svh
// assertion macros shared by the checker of the date difference block
// no dependencies; each file that asserts includes this header
`ifndef DATE_DIFFERENCE_IN_DAYS_MACROS_SVH
`define DATE_DIFFERENCE_IN_DAYS_MACROS_SVH

// checked only while out of reset
`define DD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// checked at every edge, reset included
`define DD_ASSERT_ANY(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: hw/rtl/dd_pkg.sv
// types, constants and calendar tables for the date difference block
// no dependencies; used by every module of the block
package dd_pkg;

  localparam int unsigned YEAR_W = 14;
  localparam int unsigned JD_W   = 24;
  localparam int unsigned DIFF_W = 22;

  localparam logic [YEAR_W-1:0] SWITCH_YEAR_RESET = 14'd1582;
  localparam logic [DIFF_W-1:0] DIFF_MAX          = 22'd4194303;

  // floor(x / 100) for x below 16384 as (x * 5243) >> 19
  localparam int unsigned DIV100_MUL   = 5243;
  localparam int unsigned DIV100_SHIFT = 19;

  // floor(365.25 * x) as (1461 * x) >> 2, x = year + 4716
  localparam int unsigned DAYS_PER_4Y = 1461;
  localparam int unsigned YEAR_BIAS   = 4716;

  // one converted date: validity and julian day number
  typedef struct packed {
    logic            ok;
    logic [JD_W-1:0] jd;
  } dd_date_t;

  // days in a month of a common year
  function automatic logic [4:0] month_days(input logic [3:0] month);
    logic [4:0] len;
    case (month)
      4'd2:                     len = 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:  len = 5'd30;
      default:                  len = 5'd31;
    endcase
    return len;
  endfunction

  // floor(30.6001 * (m + 1)); january and february count as months 13 and 14
  function automatic logic [8:0] month_offset(input logic [3:0] month);
    logic [8:0] ofs;
    case (month)
      4'd1:    ofs = 9'd428;
      4'd2:    ofs = 9'd459;
      4'd3:    ofs = 9'd122;
      4'd4:    ofs = 9'd153;
      4'd5:    ofs = 9'd183;
      4'd6:    ofs = 9'd214;
      4'd7:    ofs = 9'd244;
      4'd8:    ofs = 9'd275;
      4'd9:    ofs = 9'd306;
      4'd10:   ofs = 9'd336;
      4'd11:   ofs = 9'd367;
      4'd12:   ofs = 9'd397;
      default: ofs = 9'd0;
    endcase
    return ofs;
  endfunction

endpackage

FILE: hw/rtl/dd_date_conv.sv
// checks one calendar date and converts it to a julian day number, registered
// depends on dd_pkg
module dd_date_conv (
  input  logic                        clk,
  input  logic [4:0]                  day,
  input  logic [3:0]                  month,
  input  logic [dd_pkg::YEAR_W-1:0]   year,
  input  logic [dd_pkg::YEAR_W-1:0]   switch_year,
  output dd_pkg::dd_date_t            date_r
);

  logic                          greg;
  logic                          adj;
  logic                          y_neg;
  logic [26:0]                   yq_prod;
  logic [7:0]                    yq;
  logic [14:0]                   yq_x100;
  logic                          century;
  logic                          leap;
  logic [4:0]                    mlen;
  logic                          ok;
  logic [dd_pkg::YEAR_W-1:0]     ya;
  logic [26:0]                   ya_prod;
  logic [7:0]                    cent;
  logic signed [9:0]             corr;
  logic [14:0]                   yb;
  logic [25:0]                   yb_prod;
  logic [dd_pkg::JD_W-1:0]       jd;
  dd_pkg::dd_date_t              date_nxt;

  // leap year test on the year as given
  always_comb begin
    greg    = (year >= switch_year);
    yq_prod = 27'(year) * 27'(dd_pkg::DIV100_MUL);
    yq      = yq_prod[26:dd_pkg::DIV100_SHIFT];
    yq_x100 = 15'(yq) * 15'd100;
    century = (yq_x100 == {1'b0, year});
    leap    = (year[1:0] == 2'd0) && !(greg && century && (yq[1:0] != 2'd0));
  end

  // range check of month and day
  always_comb begin
    mlen = dd_pkg::month_days(month);
    if (month == 4'd2 && leap) begin
      mlen = 5'd29;
    end
    ok = (month inside {[4'd1:4'd12]}) && (day != 5'd0) && (day <= mlen);
  end

  // day number; january and february belong to the year before
  always_comb begin
    adj     = (month == 4'd1) || (month == 4'd2);
    y_neg   = adj && (year == '0);
    ya      = year - dd_pkg::YEAR_W'(adj);
    ya_prod = 27'(ya) * 27'(dd_pkg::DIV100_MUL);
    cent    = ya_prod[26:dd_pkg::DIV100_SHIFT];
    // gregorian correction 2 - a + a/4, a = -1 gives 2
    if (y_neg) begin
      corr = 10'sd2;
    end else begin
      corr = 10'sd2 - $signed({2'b00, cent}) + $signed({4'b0000, cent[7:2]});
    end
    yb      = 15'(year) + 15'(dd_pkg::YEAR_BIAS) - 15'(adj);
    yb_prod = 26'(yb) * 26'(dd_pkg::DAYS_PER_4Y);
    jd      = yb_prod[25:2]
            + dd_pkg::JD_W'(dd_pkg::month_offset(month))
            + dd_pkg::JD_W'(day);
    if (greg) begin
      jd = jd + {{(dd_pkg::JD_W-10){corr[9]}}, corr};
    end
    date_nxt.ok = ok;
    date_nxt.jd = jd;
  end

  // stage register
  always_ff @(posedge clk) begin
    date_r <= date_nxt;
  end

endmodule

FILE: hw/rtl/dd_diff.sv
// subtracts two day numbers, takes the magnitude and saturates; result register
// depends on dd_pkg
module dd_diff (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        s1_valid,
  input  dd_pkg::dd_date_t            first_date,
  input  dd_pkg::dd_date_t            second_date,
  output logic                        out_valid,
  output logic                        out_both_valid,
  output logic [dd_pkg::DIFF_W-1:0]   out_day_difference
);

  logic signed [dd_pkg::JD_W:0]  diff;
  logic [dd_pkg::JD_W:0]         mag;
  logic                          both_ok;
  logic                          out_valid_r;
  logic                          both_valid_r;
  logic [dd_pkg::DIFF_W-1:0]     day_diff_r;
  logic                          both_valid_nxt;
  logic [dd_pkg::DIFF_W-1:0]     day_diff_nxt;

  // magnitude of the difference, clamped to the field; zero if either date is invalid
  always_comb begin
    both_ok = first_date.ok && second_date.ok;
    diff    = $signed({1'b0, first_date.jd}) - $signed({1'b0, second_date.jd});
    mag     = diff[dd_pkg::JD_W] ? (~diff + 1'b1) : diff;
    if (!both_ok) begin
      day_diff_nxt = '0;
    end else if (mag > (dd_pkg::JD_W+1)'(dd_pkg::DIFF_MAX)) begin
      day_diff_nxt = dd_pkg::DIFF_MAX;
    end else begin
      day_diff_nxt = mag[dd_pkg::DIFF_W-1:0];
    end
    both_valid_nxt = both_ok;
  end

  // result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= s1_valid;
    end
  end

  // result word
  always_ff @(posedge clk) begin
    both_valid_r <= both_valid_nxt;
    day_diff_r   <= day_diff_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_both_valid     = both_valid_r;
  assign out_day_difference = day_diff_r;

endmodule

FILE: hw/rtl/date_difference_in_days.sv
// top level of the date difference block: input register, two date converters,
// difference stage and the switch year register; depends on dd_pkg
//
// Usage
//   Input: a pair of dates is taken at a rising edge with start high and busy
//   low. busy is high only during reset and in the first cycle after it;
//   afterwards a new word can be started every cycle.
//   Result: out_valid is high for exactly one cycle per accepted word, with
//   out_both_valid and out_day_difference beside it. The receiver cannot
//   stall; results must be taken when shown.
//   Pipeline: a word passes the input, day number and result registers in
//   that order; the strobe comes out with the result.
//   Throughput is one word per cycle, set by the three-stage pipeline.
//   Configuration: cfg_calendar_switch_year is written at an edge with
//   cfg_valid and cfg_ready high; cfg_ready follows busy inverted. Write it
//   only with no word in flight.
//   Reset: synchronous, active low; clears the pipeline strobes and sets the
//   switch year to 1582.
module date_difference_in_days (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [4:0]                  in_first_day,
  input  logic [3:0]                  in_first_month,
  input  logic [dd_pkg::YEAR_W-1:0]   in_first_year,
  input  logic [4:0]                  in_second_day,
  input  logic [3:0]                  in_second_month,
  input  logic [dd_pkg::YEAR_W-1:0]   in_second_year,
  output logic                        out_valid,
  output logic                        out_both_valid,
  output logic [dd_pkg::DIFF_W-1:0]   out_day_difference,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [dd_pkg::YEAR_W-1:0]   cfg_calendar_switch_year
);

  logic                          run_r;
  logic [dd_pkg::YEAR_W-1:0]     switch_year_r;
  logic                          v0_r;
  logic                          v1_r;
  logic [4:0]                    d1_r;
  logic [3:0]                    m1_r;
  logic [dd_pkg::YEAR_W-1:0]     y1_r;
  logic [4:0]                    d2_r;
  logic [3:0]                    m2_r;
  logic [dd_pkg::YEAR_W-1:0]     y2_r;
  logic                          in_fire;
  dd_pkg::dd_date_t              first_date;
  dd_pkg::dd_date_t              second_date;

  assign in_fire   = start && !busy;
  assign busy      = !(run_r && rst_n);
  assign cfg_ready = run_r && rst_n;

  // run flag and switch year register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r         <= 1'b0;
      switch_year_r <= dd_pkg::SWITCH_YEAR_RESET;
    end else begin
      run_r <= 1'b1;
      if (cfg_valid && cfg_ready) begin
        switch_year_r <= cfg_calendar_switch_year;
      end
    end
  end

  // pipeline strobes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
    end else begin
      v0_r <= in_fire;
      v1_r <= v0_r;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    d1_r <= in_first_day;
    m1_r <= in_first_month;
    y1_r <= in_first_year;
    d2_r <= in_second_day;
    m2_r <= in_second_month;
    y2_r <= in_second_year;
  end

  dd_date_conv u_conv_first (
    .clk         (clk),
    .day         (d1_r),
    .month       (m1_r),
    .year        (y1_r),
    .switch_year (switch_year_r),
    .date_r      (first_date)
  );

  dd_date_conv u_conv_second (
    .clk         (clk),
    .day         (d2_r),
    .month       (m2_r),
    .year        (y2_r),
    .switch_year (switch_year_r),
    .date_r      (second_date)
  );

  dd_diff u_diff (
    .clk                (clk),
    .rst_n              (rst_n),
    .s1_valid           (v1_r),
    .first_date         (first_date),
    .second_date        (second_date),
    .out_valid          (out_valid),
    .out_both_valid     (out_both_valid),
    .out_day_difference (out_day_difference)
  );

endmodule

FILE: hw/rtl/dd_checker.sv
// port-level checks of the date difference block, bound to its top level
// depends on dd_pkg and date_difference_in_days_macros.svh
`include "date_difference_in_days_macros.svh"

module dd_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic                        busy,
  input  logic                        out_valid,
  input  logic                        out_both_valid,
  input  logic [dd_pkg::DIFF_W-1:0]   out_day_difference
);

  // busy only around reset
  `DD_ASSERT_ANY(a_busy_after_reset, !rst_n |=> busy, "busy low right after reset")
  `DD_ASSERT(a_busy_clears, $past(rst_n) |-> !busy, "busy high outside reset")

  // every accepted word gives one result, and no result comes without a word
  `DD_ASSERT(a_result_follows, (start && !busy) |-> ##3 out_valid, "result missing")
  `DD_ASSERT(a_no_spurious, out_valid |-> $past(start && !busy, 3), "result without word")

  // invalid dates report a zero difference
  `DD_ASSERT(a_invalid_zero, (out_valid && !out_both_valid) |-> (out_day_difference == '0),
    "nonzero difference for invalid dates")

endmodule

bind date_difference_in_days dd_checker u_dd_checker (.*);
